// File: design/grid_astar_path_search_macros.svh
// assertion macros shared by the search block
`ifndef GRID_ASTAR_PATH_SEARCH_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_MACROS_SVH

// same-cycle implication, checked out of reset
`define GAP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define GAP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/gap_pkg.sv
`default_nettype none
package gap_pkg;
   localparam int GRID_DIM_DEF = 32;
   localparam int COST_W = 14;
   localparam int COUNT_W = 11;
   localparam logic [COST_W-1:0] COST_MAX = 14'd16383;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
   localparam logic [COST_W:0] STEP_STRAIGHT = 15'd10;
   localparam logic [COST_W:0] STEP_DIAG = 15'd14;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN = 1'b1;

   localparam logic [2:0] CSR_GRID_ROWS = 3'd0;
   localparam logic [2:0] CSR_GRID_COLS = 3'd1;
   localparam logic [2:0] CSR_START_ROW = 3'd2;
   localparam logic [2:0] CSR_START_COL = 3'd3;
   localparam logic [2:0] CSR_GOAL_ROW = 3'd4;
   localparam logic [2:0] CSR_GOAL_COL = 3'd5;

   typedef enum logic [1:0] {
      ST_FOUND = 2'd0,
      ST_NO_PATH = 2'd1,
      ST_OUTSIDE = 2'd2
   } status_type;

   typedef struct packed {
      logic [5:0] grid_rows;
      logic [5:0] grid_cols;
      logic [4:0] start_row;
      logic [4:0] start_col;
      logic [4:0] goal_row;
      logic [4:0] goal_col;
   } cfg_type;

   typedef struct packed {
      logic operation;
      logic [4:0] cell_row;
      logic [4:0] cell_col;
      logic blocked;
   } cmd_type;

   typedef struct packed {
      status_type status;
      logic [COST_W-1:0] path_cost;
      logic [COUNT_W-1:0] expanded_count;
   } result_type;

   typedef struct packed {
      logic open;
      logic closed;
      logic [COST_W-1:0] cost;
   } node_type;

   // neighbor order: down, up, right, left, then the four diagonals
   function automatic logic signed [1:0] step_dr(input logic [2:0] k);
      logic signed [1:0] d;
      case (k)
         3'd0, 3'd4, 3'd6: d = 2'sd1;
         3'd1, 3'd5, 3'd7: d = -2'sd1;
         default: d = 2'sd0;
      endcase
      return d;
   endfunction

   function automatic logic signed [1:0] step_dc(input logic [2:0] k);
      logic signed [1:0] d;
      case (k)
         3'd2, 3'd4, 3'd5: d = 2'sd1;
         3'd3, 3'd6, 3'd7: d = -2'sd1;
         default: d = 2'sd0;
      endcase
      return d;
   endfunction
endpackage
`default_nettype wire

// File: design/grid_astar_path_search.sv
`default_nettype none
`include "grid_astar_path_search_macros.svh"
// A* search over an 8-connected grid of up to GRID_DIM x GRID_DIM cells (straight step 10,
// diagonal 14, Manhattan heuristic). A load item writes one obstacle cell; while the block is
// idle, loads are taken one per cycle, back to back. A run item returns one result (status,
// goal cost, expansions); it first sweeps the node marks, one cell a cycle, and seeds the
// start cell, then for each expansion scans the open list for the lowest f (list read, node
// read and compare per entry), shifts the entries behind the removed one up (a read and a
// write per entry), closes the cell, reads and evaluates each of the eight neighbors inside
// the grid (skipping those outside) and checks for the goal; the open-list memory has a
// single read port. A run with the start or goal outside the grid skips the search and goes
// straight to its result. After reset the obstacle map is swept to walkable, one cell a cycle,
// with req_stall high.
// The input side stays stalled from a run until its result is in the output register.
module grid_astar_path_search #(
   parameter int GRID_DIM = gap_pkg::GRID_DIM_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic req_operation,
   input logic [4:0] req_cell_row,
   input logic [4:0] req_cell_col,
   input logic req_blocked,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic [13:0] rsp_path_cost,
   output logic [10:0] rsp_expanded_count,
   input logic csr_write_en,
   input logic [2:0] csr_index,
   input logic [5:0] csr_wdata
);
   import gap_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   result_type eng_res, rsp_ff;
   logic eng_busy, eng_res_valid, res_ack, cmd_valid;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_GRID_ROWS: cfg_in.grid_rows = csr_wdata;
            CSR_GRID_COLS: cfg_in.grid_cols = csr_wdata;
            CSR_START_ROW: cfg_in.start_row = csr_wdata[4:0];
            CSR_START_COL: cfg_in.start_col = csr_wdata[4:0];
            CSR_GOAL_ROW: cfg_in.goal_row = csr_wdata[4:0];
            CSR_GOAL_COL: cfg_in.goal_col = csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   assign cmd_valid = req_valid && !req_stall;
   assign cmd = '{operation: req_operation, cell_row: req_cell_row,
                  cell_col: req_cell_col, blocked: req_blocked};

   gap_engine #(.GRID_DIM(GRID_DIM)) u_engine (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .cmd_valid(cmd_valid), .cmd(cmd),
      .busy(eng_busy), .res_valid(eng_res_valid), .res_ack(res_ack), .res(eng_res)
   );

   // output register takes a result when empty or being drained
   assign res_ack = eng_res_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = res_ack || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{grid_rows: 6'd32, grid_cols: 6'd32, start_row: 5'd0, start_col: 5'd0,
                     goal_row: 5'd31, goal_col: 5'd31};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_ack) begin
         rsp_ff <= eng_res;
      end
   end

   assign req_stall = eng_busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_path_cost = rsp_ff.path_cost;
   assign rsp_expanded_count = rsp_ff.expanded_count;

   `GAP_ASSERT_NXT(a_run_goes_busy, clock, reset, cmd_valid && (req_operation == OP_RUN), req_stall, "run item did not make the block busy")
   `GAP_ASSERT_NXT(a_result_lands, clock, reset, res_ack, rsp_valid, "accepted result missing from output register")
   `GAP_ASSERT_IMP(a_outside_zero, clock, reset, rsp_valid && (rsp_status == ST_OUTSIDE), (rsp_path_cost == '0) && (rsp_expanded_count == '0), "outside result carries nonzero fields")
endmodule
`default_nettype wire

// File: design/gap_ram.sv
`default_nettype none
module gap_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: design/gap_engine.sv
`default_nettype none
module gap_engine #(
   parameter int GRID_DIM = gap_pkg::GRID_DIM_DEF
) (
   input logic clock,
   input logic reset,
   input gap_pkg::cfg_type cfg,
   input logic cmd_valid,
   input gap_pkg::cmd_type cmd,
   output logic busy,
   output logic res_valid,
   input logic res_ack,
   output gap_pkg::result_type res
);
   import gap_pkg::*;

   localparam int CW = $clog2(GRID_DIM);
   localparam int AW = 2 * CW;
   localparam int CELLS = 1 << AW;
   localparam int KW = AW + 1;
   localparam int NW = $bits(node_type);

   typedef enum logic [13:0] {
      S_WIPE = 14'b00000000000001,
      S_IDLE = 14'b00000000000010,
      S_CLEAR = 14'b00000000000100,
      S_INIT = 14'b00000000001000,
      S_SCAN_REQ = 14'b00000000010000,
      S_SCAN_LIST = 14'b00000000100000,
      S_SCAN_NODE = 14'b00000001000000,
      S_SHIFT_RD = 14'b00000010000000,
      S_SHIFT_WR = 14'b00000100000000,
      S_CLOSE = 14'b00001000000000,
      S_NB_RD = 14'b00010000000000,
      S_NB_EVAL = 14'b00100000000000,
      S_NEXT = 14'b01000000000000,
      S_DONE = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [KW-1:0] ptr_ff, ptr_in, count_ff, count_in, best_i_ff, best_i_in;
   logic [COST_W:0] best_f_ff, best_f_in;
   logic [AW-1:0] best_idx_ff, best_idx_in, cand_ff, cand_in, nb_ff, nb_in;
   logic [COST_W-1:0] best_cost_ff, best_cost_in, cost_out_ff, cost_out_in;
   logic [2:0] k_ff, k_in;
   logic diag_ff, diag_in;
   logic [COUNT_W-1:0] expanded_ff, expanded_in;
   status_type status_ff, status_in;

   logic node_we, list_we, obs_we;
   logic [AW-1:0] node_waddr, node_raddr, list_waddr, list_raddr, obs_waddr;
   node_type node_wdata, node_rd;
   logic [NW-1:0] node_rd_bits;
   logic [AW-1:0] list_wdata, list_rd;
   logic obs_wdata, obs_rd;

   logic [6:0] rows_eff, cols_eff;
   logic outside, load_ok;
   logic [AW-1:0] s_idx, g_idx, nb_idx;
   logic [7:0] nr, nc;
   logic in_bounds, nb_diag, nb_blocked, take_best;
   logic [6:0] dr_abs, dc_abs;
   logic [7:0] heur;
   logic [COST_W:0] f_val, ng_sum;
   logic [COST_W-1:0] ng;
   logic [KW-1:0] ptr_next, best_sel;

   gap_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obstacle (
      .clock(clock), .wr_en(obs_we), .wr_addr(obs_waddr), .wr_data(obs_wdata),
      .rd_addr(nb_idx), .rd_data(obs_rd)
   );
   gap_ram #(.WIDTH(NW), .DEPTH(CELLS)) u_node (
      .clock(clock), .wr_en(node_we), .wr_addr(node_waddr), .wr_data(node_wdata),
      .rd_addr(node_raddr), .rd_data(node_rd_bits)
   );
   gap_ram #(.WIDTH(AW), .DEPTH(CELLS)) u_open_list (
      .clock(clock), .wr_en(list_we), .wr_addr(list_waddr), .wr_data(list_wdata),
      .rd_addr(list_raddr), .rd_data(list_rd)
   );
   assign node_rd = node_type'(node_rd_bits);

   // grid geometry
   assign rows_eff = (7'(cfg.grid_rows) > 7'(GRID_DIM)) ? 7'(GRID_DIM) : 7'(cfg.grid_rows);
   assign cols_eff = (7'(cfg.grid_cols) > 7'(GRID_DIM)) ? 7'(GRID_DIM) : 7'(cfg.grid_cols);
   assign outside = (7'(cfg.start_row) >= rows_eff) || (7'(cfg.start_col) >= cols_eff) ||
                    (7'(cfg.goal_row) >= rows_eff) || (7'(cfg.goal_col) >= cols_eff);
   assign load_ok = (7'(cmd.cell_row) < 7'(GRID_DIM)) && (7'(cmd.cell_col) < 7'(GRID_DIM));
   assign s_idx = {CW'(cfg.start_row), CW'(cfg.start_col)};
   assign g_idx = {CW'(cfg.goal_row), CW'(cfg.goal_col)};

   // neighbor address of the expanded cell
   assign nr = 8'(best_idx_ff[AW-1:CW]) + 8'(step_dr(k_ff));
   assign nc = 8'(best_idx_ff[CW-1:0]) + 8'(step_dc(k_ff));
   assign in_bounds = !nr[7] && !nc[7] && (nr < 8'(rows_eff)) && (nc < 8'(cols_eff));
   assign nb_idx = {nr[CW-1:0], nc[CW-1:0]};
   assign nb_diag = (step_dr(k_ff) != 2'sd0) && (step_dc(k_ff) != 2'sd0);

   // shared arithmetic: f of a scanned entry, g of a neighbor
   assign dr_abs = (7'(cand_ff[AW-1:CW]) > 7'(cfg.goal_row)) ?
                   7'(cand_ff[AW-1:CW]) - 7'(cfg.goal_row) : 7'(cfg.goal_row) - 7'(cand_ff[AW-1:CW]);
   assign dc_abs = (7'(cand_ff[CW-1:0]) > 7'(cfg.goal_col)) ?
                   7'(cand_ff[CW-1:0]) - 7'(cfg.goal_col) : 7'(cfg.goal_col) - 7'(cand_ff[CW-1:0]);
   assign heur = 8'(dr_abs) + 8'(dc_abs);
   assign f_val = {1'b0, node_rd.cost} + 15'(heur);
   assign ng_sum = {1'b0, best_cost_ff} + (diag_ff ? STEP_DIAG : STEP_STRAIGHT);
   assign ng = (ng_sum > {1'b0, COST_MAX}) ? COST_MAX : ng_sum[COST_W-1:0];
   assign nb_blocked = obs_rd && (nb_ff != s_idx) && (nb_ff != g_idx);

   assign ptr_next = ptr_ff + KW'(1);
   assign take_best = (ptr_ff == '0) || (f_val < best_f_ff);
   assign best_sel = take_best ? ptr_ff : best_i_ff;

   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      count_in = count_ff;
      best_i_in = best_i_ff;
      best_f_in = best_f_ff;
      best_idx_in = best_idx_ff;
      best_cost_in = best_cost_ff;
      cand_in = cand_ff;
      nb_in = nb_ff;
      k_in = k_ff;
      diag_in = diag_ff;
      expanded_in = expanded_ff;
      status_in = status_ff;
      cost_out_in = cost_out_ff;
      node_we = 1'b0;
      node_waddr = ptr_ff[AW-1:0];
      node_wdata = '0;
      node_raddr = '0;
      list_we = 1'b0;
      list_waddr = ptr_ff[AW-1:0];
      list_wdata = list_rd;
      list_raddr = '0;
      obs_we = 1'b0;
      obs_waddr = ptr_ff[AW-1:0];
      obs_wdata = 1'b0;
      case (state_ff)
         S_WIPE: begin
            obs_we = 1'b1;
            ptr_in = ptr_next;
            if (ptr_ff[AW-1:0] == {AW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               if (cmd.operation == OP_LOAD) begin
                  obs_we = load_ok;
                  obs_waddr = {CW'(cmd.cell_row), CW'(cmd.cell_col)};
                  obs_wdata = cmd.blocked;
               end else if (outside) begin
                  status_in = ST_OUTSIDE;
                  cost_out_in = '0;
                  expanded_in = '0;
                  state_in = S_DONE;
               end else begin
                  ptr_in = '0;
                  expanded_in = '0;
                  state_in = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            node_we = 1'b1;
            ptr_in = ptr_next;
            if (ptr_ff[AW-1:0] == {AW{1'b1}}) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            node_we = 1'b1;
            node_waddr = s_idx;
            node_wdata = '{open: 1'b1, closed: 1'b0, cost: '0};
            list_we = 1'b1;
            list_waddr = '0;
            list_wdata = s_idx;
            count_in = KW'(1);
            ptr_in = '0;
            state_in = S_SCAN_REQ;
         end
         S_SCAN_REQ: begin
            list_raddr = ptr_ff[AW-1:0];
            state_in = S_SCAN_LIST;
         end
         S_SCAN_LIST: begin
            node_raddr = list_rd;
            cand_in = list_rd;
            state_in = S_SCAN_NODE;
         end
         S_SCAN_NODE: begin
            // strict less-than keeps the earliest entry on ties
            if (take_best) begin
               best_f_in = f_val;
               best_i_in = ptr_ff;
               best_idx_in = cand_ff;
               best_cost_in = node_rd.cost;
            end
            if (ptr_next == count_ff) begin
               ptr_in = best_sel;
               state_in = S_SHIFT_RD;
            end else begin
               ptr_in = ptr_next;
               state_in = S_SCAN_REQ;
            end
         end
         S_SHIFT_RD: begin
            if (ptr_next < count_ff) begin
               list_raddr = ptr_next[AW-1:0];
               state_in = S_SHIFT_WR;
            end else begin
               state_in = S_CLOSE;
            end
         end
         S_SHIFT_WR: begin
            list_we = 1'b1;
            ptr_in = ptr_next;
            state_in = S_SHIFT_RD;
         end
         S_CLOSE: begin
            count_in = count_ff - KW'(1);
            node_we = 1'b1;
            node_waddr = best_idx_ff;
            node_wdata = '{open: 1'b0, closed: 1'b1, cost: best_cost_ff};
            if (expanded_ff != COUNT_MAX) begin
               expanded_in = expanded_ff + COUNT_W'(1);
            end
            k_in = '0;
            state_in = S_NB_RD;
         end
         S_NB_RD: begin
            node_raddr = nb_idx;
            if (in_bounds) begin
               nb_in = nb_idx;
               diag_in = nb_diag;
               state_in = S_NB_EVAL;
            end else if (k_ff == 3'd7) begin
               state_in = S_NEXT;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         S_NB_EVAL: begin
            if (!nb_blocked && !node_rd.closed) begin
               if (!node_rd.open) begin
                  node_we = 1'b1;
                  node_waddr = nb_ff;
                  node_wdata = '{open: 1'b1, closed: 1'b0, cost: ng};
                  if (count_ff < KW'(CELLS)) begin
                     list_we = 1'b1;
                     list_waddr = count_ff[AW-1:0];
                     list_wdata = nb_ff;
                     count_in = count_ff + KW'(1);
                  end
               end else if (ng < node_rd.cost) begin
                  node_we = 1'b1;
                  node_waddr = nb_ff;
                  node_wdata = '{open: 1'b1, closed: 1'b0, cost: ng};
               end
            end
            k_in = k_ff + 3'd1;
            state_in = (k_ff == 3'd7) ? S_NEXT : S_NB_RD;
         end
         S_NEXT: begin
            if (best_idx_ff == g_idx) begin
               status_in = ST_FOUND;
               cost_out_in = best_cost_ff;
               state_in = S_DONE;
            end else if (count_ff == '0) begin
               status_in = ST_NO_PATH;
               cost_out_in = '0;
               state_in = S_DONE;
            end else begin
               ptr_in = '0;
               state_in = S_SCAN_REQ;
            end
         end
         S_DONE: begin
            if (res_ack) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WIPE;
         ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         count_ff <= count_in;
      end
      best_i_ff <= best_i_in;
      best_f_ff <= best_f_in;
      best_idx_ff <= best_idx_in;
      best_cost_ff <= best_cost_in;
      cand_ff <= cand_in;
      nb_ff <= nb_in;
      k_ff <= k_in;
      diag_ff <= diag_in;
      expanded_ff <= expanded_in;
      status_ff <= status_in;
      cost_out_ff <= cost_out_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res = '{status: status_ff, path_cost: cost_out_ff, expanded_count: expanded_ff};
endmodule
`default_nettype wire

// File: tb/sv/tb_grid_astar_path_search.sv
module tb_grid_astar_path_search;
   timeunit 1ns;
   timeprecision 1ps;
   import gap_pkg::*;

   localparam int CELL_COUNT = 1024;
   localparam longint CYCLE_LIMIT = 20_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_operation = OP_LOAD;
   logic [4:0] req_cell_row = '0;
   logic [4:0] req_cell_col = '0;
   logic req_blocked = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [13:0] rsp_path_cost;
   logic [10:0] rsp_expanded_count;
   logic csr_write_en = 1'b0;
   logic [2:0] csr_index = CSR_GRID_ROWS;
   logic [5:0] csr_wdata = '0;

   grid_astar_path_search dut (.*);

   always #5 clock = ~clock;

   // shadow copies of the obstacle map and the registers
   bit obstacle[CELL_COUNT];
   int sh_rows = 32, sh_cols = 32, sh_srow = 0, sh_scol = 0, sh_grow = 31, sh_gcol = 31;

   result_type search_results[$];
   int mismatches = 0;
   int send_gap_pct = 0;
   int rx_stall_pct = 0;
   longint cycles = 0;

   function automatic int absdiff(int a, int b);
      return a > b ? a - b : b - a;
   endfunction

   // a* over the shadow map, open list kept in entry order
   function automatic result_type search_goal();
      result_type r;
      int rows, cols, s, gl, cnt, best, bestf, f, cur, nr, nc, n, ng, expd, i, k;
      bit closed[CELL_COUNT];
      bit opn[CELL_COUNT];
      int cost[CELL_COUNT];
      int order[CELL_COUNT];
      int dr[8] = '{1, -1, 0, 0, 1, -1, 1, -1};
      int dc[8] = '{0, 0, 1, -1, 1, 1, -1, -1};
      r.status = ST_OUTSIDE;
      r.path_cost = '0;
      r.expanded_count = '0;
      rows = sh_rows > 32 ? 32 : sh_rows;
      cols = sh_cols > 32 ? 32 : sh_cols;
      if (sh_srow >= rows || sh_scol >= cols || sh_grow >= rows || sh_gcol >= cols)
         return r;
      s = sh_srow * 32 + sh_scol;
      gl = sh_grow * 32 + sh_gcol;
      opn[s] = 1;
      cost[s] = 0;
      order[0] = s;
      cnt = 1;
      expd = 0;
      while (cnt > 0) begin
         best = 0;
         bestf = cost[order[0]] + absdiff(order[0] / 32, sh_grow) +
                 absdiff(order[0] % 32, sh_gcol);
         for (i = 1; i < cnt; i++) begin
            f = cost[order[i]] + absdiff(order[i] / 32, sh_grow) +
                absdiff(order[i] % 32, sh_gcol);
            if (f < bestf) begin
               bestf = f;
               best = i;
            end
         end
         cur = order[best];
         for (i = best; i < cnt - 1; i++) order[i] = order[i + 1];
         cnt--;
         opn[cur] = 0;
         closed[cur] = 1;
         if (expd < 2047) expd++;
         for (k = 0; k < 8; k++) begin
            nr = cur / 32 + dr[k];
            nc = cur % 32 + dc[k];
            if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
            n = nr * 32 + nc;
            if (obstacle[n] && n != s && n != gl) continue;
            if (closed[n]) continue;
            ng = cost[cur] + ((dr[k] != 0 && dc[k] != 0) ? 14 : 10);
            if (ng > 16383) ng = 16383;
            if (!opn[n]) begin
               opn[n] = 1;
               cost[n] = ng;
               if (cnt < CELL_COUNT) begin
                  order[cnt] = n;
                  cnt++;
               end
            end else if (ng < cost[n]) begin
               cost[n] = ng;
            end
         end
         if (closed[gl]) begin
            r.status = ST_FOUND;
            r.path_cost = 14'(cost[gl]);
            r.expanded_count = 11'(expd);
            return r;
         end
      end
      r.status = ST_NO_PATH;
      r.expanded_count = 11'(expd);
      return r;
   endfunction

   // result side: random stall, compare against oldest expectation
   always @(posedge clock) begin
      result_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (search_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result status=%0d cost=%0d count=%0d",
               rsp_status, rsp_path_cost, rsp_expanded_count);
         end else begin
            want = search_results.pop_front();
            if (rsp_status !== want.status || rsp_path_cost !== want.path_cost ||
                rsp_expanded_count !== want.expanded_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp status=%0d cost=%0d count=%0d, got %0d %0d %0d",
                     want.status, want.path_cost, want.expanded_count,
                     rsp_status, rsp_path_cost, rsp_expanded_count);
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
   end

   task automatic send_item(logic op, logic [4:0] row, logic [4:0] col, logic blk);
      // sender idles cycle by cycle with the set percentage
      if ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_cell_row <= row;
      req_cell_col <= col;
      req_blocked <= blk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_LOAD) obstacle[row * 32 + col] = blk;
      else search_results = {search_results, search_goal()};
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (search_results.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [5:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic set_grid(int rows, int cols, int srow, int scol, int grow, int gcol);
      wait_idle();
      write_csr(CSR_GRID_ROWS, 6'(rows));
      write_csr(CSR_GRID_COLS, 6'(cols));
      write_csr(CSR_START_ROW, 6'(srow));
      write_csr(CSR_START_COL, 6'(scol));
      write_csr(CSR_GOAL_ROW, 6'(grow));
      write_csr(CSR_GOAL_COL, 6'(gcol));
      csr_write_en <= 1'b0;
      sh_rows = rows & 63;
      sh_cols = cols & 63;
      sh_srow = srow & 31;
      sh_scol = scol & 31;
      sh_grow = grow & 31;
      sh_gcol = gcol & 31;
   endtask

   task automatic run_search_item();
      send_item(OP_RUN, 5'($urandom), 5'($urandom), 1'($urandom));
   endtask

   task automatic test_reset_grid();
      // full 32x32 grid from the reset registers, corner to corner
      run_search_item();
   endtask

   task automatic test_corner_cases();
      send_item(OP_LOAD, 5'd0, 5'd0, 1'b1);
      send_item(OP_LOAD, 5'd31, 5'd31, 1'b1);
      set_grid(63, 63, 31, 31, 29, 30);
      run_search_item();
      set_grid(0, 5, 0, 0, 0, 0);
      run_search_item();
      set_grid(4, 4, 5, 0, 1, 1);
      run_search_item();
      set_grid(4, 4, 1, 1, 1, 4);
      run_search_item();
      set_grid(1, 1, 0, 0, 0, 0);
      run_search_item();
      // wall across a 3x3 grid
      set_grid(3, 3, 0, 0, 2, 2);
      send_item(OP_LOAD, 5'd1, 5'd0, 1'b1);
      send_item(OP_LOAD, 5'd1, 5'd1, 1'b1);
      send_item(OP_LOAD, 5'd1, 5'd2, 1'b1);
      run_search_item();
      send_item(OP_LOAD, 5'd1, 5'd2, 1'b0);
      send_item(OP_LOAD, 5'd0, 5'd0, 1'b0);
      send_item(OP_LOAD, 5'd31, 5'd31, 1'b0);
      run_search_item();
   endtask

   task automatic test_random_mazes(int items);
      int sent, rows, cols, srow, scol, grow, gcol, loads, runs;
      sent = 0;
      while (sent < items) begin
         rows = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
         cols = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
         srow = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 31) : $urandom_range(0, rows - 1);
         scol = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 31) : $urandom_range(0, cols - 1);
         grow = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 31) : $urandom_range(0, rows - 1);
         gcol = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 31) : $urandom_range(0, cols - 1);
         set_grid(rows, cols, srow, scol, grow, gcol);
         loads = $urandom_range(0, 10);
         for (int i = 0; i < loads; i++) begin
            if ($urandom_range(0, 5) == 0)
               send_item(OP_LOAD, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                  1'($urandom));
            else
               send_item(OP_LOAD, 5'($urandom_range(0, rows - 1)),
                  5'($urandom_range(0, cols - 1)), $urandom_range(0, 99) < 30);
         end
         runs = $urandom_range(1, 2);
         repeat (runs) run_search_item();
         sent += loads + runs;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      test_reset_grid();
      test_corner_cases();
      send_gap_pct = 27;
      rx_stall_pct = 81;
      test_random_mazes(200);
      send_gap_pct = 81;
      rx_stall_pct = 27;
      test_random_mazes(200);
      send_gap_pct = 0;
      rx_stall_pct = 0;
      test_random_mazes(200);
      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && search_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// File: grid_astar_path_search.f
+incdir+design
design/gap_pkg.sv
design/gap_ram.sv
design/gap_engine.sv
design/grid_astar_path_search.sv
tb/sv/tb_grid_astar_path_search.sv
